// ----- src/sds_pkg.sv -----
// Shared types and constants for the sumset decomposition search block.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

  localparam int MASK_W = 32;  // width of the support mask
  localparam int POS_W  = 5;   // exponent index width
  localparam int CNT_W  = 6;   // element counts, 0..32
  localparam int MID_N  = 32;  // middle candidate slots

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_CHECK, ST_PAIRS, ST_PRUNE, ST_AMAX, ST_MID,
    ST_CAND, ST_BAND, ST_TEST, ST_SEEN, ST_NEXT, ST_EMIT
  } sds_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCAN, OP_PAIR_INIT, OP_PAIR, OP_AMAX_INIT, OP_AMAX_DEC,
    OP_MID_INIT, OP_MID, OP_CAND, OP_BAND, OP_SEEN_INIT, OP_SEEN, OP_CNT_INC,
    OP_EMIT
  } sds_op_t;

  typedef struct packed {
    sds_op_t op;
    logic    found;
  } sds_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic chk_fail;
    logic pair_last;
    logic prune_fail;
    logic amax_zero;
    logic amax_ok;
    logic mid_last;
    logic rem_zero;
    logic test_pass;
    logic seen_match;
    logic cnt_last;
    logic out_free;
  } sds_status_t;

endpackage
`default_nettype wire

// ----- src/sds_datapath.sv -----
// Datapath: support analysis, candidate registers, B intersection and cover check.
`timescale 1ns / 1ps
`default_nettype none
module sds_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [sds_pkg::MASK_W-1:0]  in_support_mask,
  input  wire sds_pkg::sds_cmd_t           cmd,
  output sds_pkg::sds_status_t             status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic [sds_pkg::MASK_W-1:0]       out_a_mask,
  output logic [sds_pkg::MASK_W-1:0]       out_b_mask
);

  localparam int W  = sds_pkg::MASK_W;
  localparam int PW = sds_pkg::POS_W;
  localparam int CW = sds_pkg::CNT_W;

  function automatic logic [PW-1:0] lsb_index(input logic [W-1:0] v);
    logic [PW-1:0] idx;
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (v[i]) idx = PW'(i);
    end
    return idx;
  endfunction

  function automatic logic [CW-1:0] pop32(input logic [W-1:0] v);
    logic [CW-1:0] c;
    c = '0;
    for (int i = 0; i < W; i++) c = c + CW'(v[i]);
    return c;
  endfunction

  logic [W-1:0]    s_r, amask_r, rem_r, bmask_r, seen_r, cnt_r;
  logic [PW-1:0]   k_r, deg_r, minpos_r, px_r, amax_r, bmax_r;
  logic [CW-1:0]   n_r, m_r, asize_r;
  logic [1:0]      pairs_r;
  logic [PW-1:0]   mid_r [sds_pkg::MID_N];
  logic            out_valid_r, out_found_r;
  logic [W-1:0]    out_a_r, out_b_r;

  logic [PW-1:0]   y, bm, a_idx;
  logic            pair_hit, mid_hit;
  logic [PW:0]     sum1, sum2;
  logic            in1, in2;
  logic [W-1:0]    amask_c, blow, cnt_top;
  logic [CW-1:0]   popb;
  logic [2*CW-1:0] prod;

  // Combinational decode of the current step
  always_comb begin
    y        = deg_r - k_r;
    pair_hit = s_r[k_r] && (k_r <= y) && s_r[y];
    sum1     = {1'b0, px_r} + {1'b0, minpos_r};
    sum2     = {1'b0, deg_r - px_r} + {1'b0, minpos_r};
    in1      = (sum1 <= {1'b0, deg_r}) && s_r[sum1[PW-1:0]];
    in2      = (sum2 <= {1'b0, deg_r}) && s_r[sum2[PW-1:0]];
    bm       = deg_r - amax_r;
    mid_hit  = (k_r != '0) && s_r[k_r] && s_r[PW'(k_r + bmax_r)];
    amask_c  = W'(1) | (W'(1) << amax_r);
    for (int i = 0; i < sds_pkg::MID_N; i++) begin
      if (cnt_r[i]) amask_c = amask_c | (W'(1) << mid_r[i]);
    end
    blow     = {W{1'b1}} >> (PW'(W - 1) - bmax_r);
    a_idx    = lsb_index(rem_r);
    popb     = pop32(bmask_r);
    prod     = asize_r * popb;
    cnt_top  = (W'(1) << m_r) - W'(1);

    status.scan_last  = (k_r == PW'(W - 1));
    status.chk_fail   = (n_r < CW'(3)) || !s_r[0];
    status.pair_last  = (k_r == deg_r - PW'(1));
    status.prune_fail = (pairs_r == 2'd0) || ((pairs_r == 2'd1) && !in1 && !in2);
    status.amax_zero  = (amax_r == '0);
    status.amax_ok    = s_r[amax_r] && (bm != '0) && (amax_r <= bm) && s_r[bm];
    status.mid_last   = (k_r <= PW'(1));
    status.rem_zero   = (rem_r == '0);
    status.test_pass  = (popb >= CW'(2)) && bmask_r[0] && bmask_r[bmax_r] &&
                        (prod >= {{CW{1'b0}}, n_r});
    status.seen_match = (seen_r == s_r);
    status.cnt_last   = (cnt_r == cnt_top);
    status.out_free   = !out_valid_r || out_ready;
  end

  // Work registers, advanced by the controller's command
  always_ff @(posedge clk) begin
    case (cmd.op)
      sds_pkg::OP_LOAD: begin
        s_r      <= in_support_mask;
        k_r      <= '0;
        n_r      <= '0;
        deg_r    <= '0;
        minpos_r <= '0;
      end
      sds_pkg::OP_SCAN: begin
        if (s_r[k_r]) begin
          n_r   <= n_r + CW'(1);
          deg_r <= k_r;
          if (k_r != '0 && minpos_r == '0) minpos_r <= k_r;
        end
        k_r <= k_r + PW'(1);
      end
      sds_pkg::OP_PAIR_INIT: begin
        k_r     <= PW'(1);
        pairs_r <= 2'd0;
        px_r    <= '0;
      end
      sds_pkg::OP_PAIR: begin
        if (pair_hit) begin
          if (pairs_r == 2'd0) px_r <= k_r;
          if (pairs_r != 2'd2) pairs_r <= pairs_r + 2'd1;
        end
        k_r <= k_r + PW'(1);
      end
      sds_pkg::OP_AMAX_INIT: amax_r <= deg_r;
      sds_pkg::OP_AMAX_DEC:  amax_r <= amax_r - PW'(1);
      sds_pkg::OP_MID_INIT: begin
        bmax_r <= bm;
        k_r    <= amax_r - PW'(1);
        m_r    <= '0;
        cnt_r  <= '0;
      end
      sds_pkg::OP_MID: begin
        if (mid_hit) begin
          mid_r[m_r[PW-1:0]] <= k_r;
          m_r <= m_r + CW'(1);
        end
        if (k_r != '0) k_r <= k_r - PW'(1);
      end
      sds_pkg::OP_CAND: begin
        amask_r <= amask_c;
        rem_r   <= amask_c;
        bmask_r <= s_r & blow;
        asize_r <= '0;
      end
      sds_pkg::OP_BAND: begin
        bmask_r <= bmask_r & (s_r >> a_idx);
        asize_r <= asize_r + CW'(1);
        rem_r   <= rem_r & (rem_r - W'(1));
      end
      sds_pkg::OP_SEEN_INIT: begin
        rem_r  <= amask_r;
        seen_r <= '0;
      end
      sds_pkg::OP_SEEN: begin
        seen_r <= seen_r | (bmask_r << a_idx);
        rem_r  <= rem_r & (rem_r - W'(1));
      end
      sds_pkg::OP_CNT_INC: cnt_r <= cnt_r + W'(1);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == sds_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sds_pkg::OP_EMIT) begin
      out_found_r <= cmd.found;
      out_a_r     <= cmd.found ? amask_r : '0;
      out_b_r     <= cmd.found ? bmask_r : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_a_mask = out_a_r;
  assign out_b_mask = out_b_r;

endmodule
`default_nettype wire

// ----- src/sds_ctrl.sv -----
// Controller state machine sequencing the decomposition search.
`timescale 1ns / 1ps
`default_nettype none
module sds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sds_pkg::sds_status_t status,
  output sds_pkg::sds_cmd_t         cmd
);

  sds_pkg::sds_state_t state_r, state_nxt;
  logic                found_r, found_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sds_pkg::ST_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    cmd.op    = sds_pkg::OP_NONE;
    cmd.found = found_r;
    in_ready  = 1'b0;
    case (state_r)
      sds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = sds_pkg::OP_LOAD;
          state_nxt = sds_pkg::ST_SCAN;
        end
      end
      sds_pkg::ST_SCAN: begin
        cmd.op = sds_pkg::OP_SCAN;
        if (status.scan_last) state_nxt = sds_pkg::ST_CHECK;
      end
      sds_pkg::ST_CHECK: begin
        if (status.chk_fail) begin
          found_nxt = 1'b0;
          state_nxt = sds_pkg::ST_EMIT;
        end else begin
          cmd.op    = sds_pkg::OP_PAIR_INIT;
          state_nxt = sds_pkg::ST_PAIRS;
        end
      end
      sds_pkg::ST_PAIRS: begin
        cmd.op = sds_pkg::OP_PAIR;
        if (status.pair_last) state_nxt = sds_pkg::ST_PRUNE;
      end
      sds_pkg::ST_PRUNE: begin
        if (status.prune_fail) begin
          found_nxt = 1'b0;
          state_nxt = sds_pkg::ST_EMIT;
        end else begin
          cmd.op    = sds_pkg::OP_AMAX_INIT;
          state_nxt = sds_pkg::ST_AMAX;
        end
      end
      sds_pkg::ST_AMAX: begin
        if (status.amax_zero) begin
          found_nxt = 1'b0;
          state_nxt = sds_pkg::ST_EMIT;
        end else if (status.amax_ok) begin
          cmd.op    = sds_pkg::OP_MID_INIT;
          state_nxt = sds_pkg::ST_MID;
        end else begin
          cmd.op = sds_pkg::OP_AMAX_DEC;
        end
      end
      sds_pkg::ST_MID: begin
        cmd.op = sds_pkg::OP_MID;
        if (status.mid_last) state_nxt = sds_pkg::ST_CAND;
      end
      sds_pkg::ST_CAND: begin
        cmd.op    = sds_pkg::OP_CAND;
        state_nxt = sds_pkg::ST_BAND;
      end
      sds_pkg::ST_BAND: begin
        if (status.rem_zero) state_nxt = sds_pkg::ST_TEST;
        else cmd.op = sds_pkg::OP_BAND;
      end
      sds_pkg::ST_TEST: begin
        if (status.test_pass) begin
          cmd.op    = sds_pkg::OP_SEEN_INIT;
          state_nxt = sds_pkg::ST_SEEN;
        end else begin
          state_nxt = sds_pkg::ST_NEXT;
        end
      end
      sds_pkg::ST_SEEN: begin
        if (!status.rem_zero) begin
          cmd.op = sds_pkg::OP_SEEN;
        end else if (status.seen_match) begin
          found_nxt = 1'b1;
          state_nxt = sds_pkg::ST_EMIT;
        end else begin
          state_nxt = sds_pkg::ST_NEXT;
        end
      end
      sds_pkg::ST_NEXT: begin
        if (status.cnt_last) begin
          cmd.op    = sds_pkg::OP_AMAX_DEC;
          state_nxt = sds_pkg::ST_AMAX;
        end else begin
          cmd.op    = sds_pkg::OP_CNT_INC;
          state_nxt = sds_pkg::ST_CAND;
        end
      end
      sds_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.op    = sds_pkg::OP_EMIT;
          state_nxt = sds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sds_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/sumset_decomposition_search_top.sv -----
// Search length: the search ends early when S has under three elements or lacks 0, or
// when the pair prune rejects; else it runs the per-amax scans plus a band pass over |A|
// per enumerated subset (and a cover pass when the cover is checked); 2^m subsets per amax.
// Throughput: one item at a time; the scan loops and the shared shift/AND unit set the time.
// The result waits in an output register; the next item is taken once the search ends.
// Reset: synchronous active-low rst_n clears controller state and output valid.
`timescale 1ns / 1ps
`default_nettype none
module sumset_decomposition_search_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_support_mask,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [31:0]      out_a_mask,
  output logic [31:0]      out_b_mask
);

  sds_pkg::sds_cmd_t    cmd;
  sds_pkg::sds_status_t status;

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sds_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_support_mask (in_support_mask),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_a_mask      (out_a_mask),
    .out_b_mask      (out_b_mask)
  );

  // Busy after an input transfer
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while search running");

  // Emit only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == sds_pkg::OP_EMIT) |-> status.out_free)
    else $error("result overwrote a pending transfer");

  // Not-found results carry empty masks
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == sds_pkg::OP_EMIT && !cmd.found) |=>
      (out_valid && !out_found && out_a_mask == 32'd0 && out_b_mask == 32'd0))
    else $error("not-found result with nonzero masks");

endmodule
`default_nettype wire

// ----- sim/sumset_decomposition_search_checker.sv -----
// Channel monitor, sumset search predictor and result comparison.
`timescale 1ns / 1ps
module sumset_decomposition_search_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_support_mask,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_found,
  input  logic [31:0] out_a_mask,
  input  logic [31:0] out_b_mask,
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic        found;
    logic [31:0] a_mask;
    logic [31:0] b_mask;
  } decomp_t;

  decomp_t decomp_q[$];

  function automatic int count_ones(logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) n += v[i];
    return n;
  endfunction

  function automatic logic [63:0] mask_upto(int top);
    return 64'hFFFF_FFFF_FFFF_FFFF >> (63 - top);
  endfunction

  function automatic bit has_elem(logic [63:0] s, int deg, int z);
    return z >= 0 && z <= deg && s[z];
  endfunction

  // Search for A + B = S; the first cover in enumeration order wins.
  function automatic decomp_t find_decomp(logic [31:0] mask);
    decomp_t     r;
    logic [63:0] s, amask, bmask, seen;
    int          deg, n, pairs, px, py, minpos, bmax, m, asize;
    int          mid[64];
    r = '0;
    s = {32'd0, mask};
    n = count_ones(s);
    deg = 0; pairs = 0; px = -1; py = -1; minpos = 0;
    if (n < 3 || !s[0]) return r;
    for (int k = 0; k < 64; k++) if (s[k]) deg = k;
    // count complement pairs, keep the one with the smallest low member
    for (int k = 1; k < deg; k++) begin
      if (s[k] && k <= deg - k && s[deg - k]) begin
        if (pairs == 0 || k < px) begin
          px = k;
          py = deg - k;
        end
        pairs++;
      end
    end
    if (pairs == 0) return r;
    if (pairs == 1) begin
      for (int k = deg; k >= 1; k--) if (s[k]) minpos = k;
      if (!has_elem(s, deg, px + minpos) && !has_elem(s, deg, py + minpos)) return r;
    end
    for (int amax = deg; amax >= 1; amax--) begin
      bmax = deg - amax;
      if (!s[amax] || bmax <= 0 || amax > bmax || !s[bmax]) continue;
      m = 0;
      for (int k = amax - 1; k >= 1; k--)
        if (s[k] && has_elem(s, deg, k + bmax)) begin
          mid[m] = k;
          m++;
        end
      for (longint unsigned cnt = 0; m < 63 && cnt < (64'd1 << m); cnt++) begin
        amask = 64'd1 | (64'd1 << amax);
        bmask = s & mask_upto(bmax);
        seen = '0;
        asize = 2;
        for (int i = 0; i < m; i++)
          if (cnt[i]) begin
            amask |= 64'd1 << mid[i];
            asize++;
          end
        for (int k = 0; k <= deg; k++) if (amask[k]) bmask &= s >> k;
        if (count_ones(bmask) < 2 || !bmask[0] || !bmask[bmax] ||
            asize * count_ones(bmask) < n) continue;
        for (int k = 0; k <= deg; k++) if (amask[k]) seen |= bmask << k;
        if (seen == s) begin
          r.found = 1'b1;
          r.a_mask = amask[31:0];
          r.b_mask = bmask[31:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    decomp_t want;
    if (!rst_n) begin
      err_count = 0;
      decomp_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) decomp_q = {decomp_q, find_decomp(in_support_mask)};
      if (out_valid && out_ready) begin
        if (decomp_q.size() == 0) begin
          $display("%0t result transfer with nothing pending", $realtime);
          err_count++;
        end else begin
          want = decomp_q.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", 32'(out_found), 32'(want.found));
          if (out_a_mask !== want.a_mask) report_mismatch("a_mask", out_a_mask, want.a_mask);
          if (out_b_mask !== want.b_mask) report_mismatch("b_mask", out_b_mask, want.b_mask);
        end
      end
      pending <= decomp_q.size();
    end
  end

endmodule

// ----- sim/sumset_decomposition_search_top_tb.sv -----
// Stimulus, handshake pacing and verdict for the sumset decomposition search block.
`timescale 1ns / 1ps
module sumset_decomposition_search_top_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_support_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [31:0] out_a_mask, out_b_mask;
  int          err_count, pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  sumset_decomposition_search_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_support_mask(in_support_mask),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_a_mask(out_a_mask), .out_b_mask(out_b_mask)
  );

  sumset_decomposition_search_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_support_mask(in_support_mask),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_a_mask(out_a_mask), .out_b_mask(out_b_mask),
    .err_count(err_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one mask and hold it until the transfer, then idle at random.
  task automatic send_mask(logic [31:0] mask);
    in_valid <= 1'b1;
    in_support_mask <= mask;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_support_mask <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Sum set of two small random sets that both contain zero.
  function automatic logic [31:0] sumset_mask();
    logic [31:0] a, b, s;
    int          reach;
    reach = $urandom_range(3) == 0 ? 15 : 7;
    a = 32'd1;
    b = 32'd1;
    s = '0;
    for (int i = 0; i < 2; i++) begin
      if ($urandom_range(1)) a[$urandom_range(reach, 1)] = 1'b1;
      if ($urandom_range(1)) b[$urandom_range(reach, 1)] = 1'b1;
    end
    for (int k = 0; k < 16; k++) if (a[k]) s |= b << k;
    return s;
  endfunction

  function automatic logic [31:0] noise_mask();
    logic [31:0] s;
    s = '0;
    if ($urandom_range(1)) begin
      // sparse over the full width
      repeat ($urandom_range(6, 2)) s[$urandom_range(31)] = 1'b1;
      s[0] = $urandom_range(3) != 0;
    end else begin
      s = $urandom & 32'h0000_1FFF;
    end
    return s;
  endfunction

  logic [31:0] directed[$] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 32'h0000_0005, 32'h0000_0006,
    32'h0000_0007, 32'h0000_000B, 32'h0000_0017, 32'h0000_002D, 32'h0000_012B,
    32'h0000_009B, 32'h0000_0099, 32'h0000_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_0001, 32'h8000_0001, 32'h8000_8001, 32'hFFFF_FFFF, 32'h0000_0E07
  };

  initial begin
    int phase_idle[4] = '{0, 75, 0, 36};
    int phase_stall[4] = '{0, 0, 75, 36};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_mask(directed[i]);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 30; i++) begin
        send_mask($urandom_range(3) != 0 ? sumset_mask() : noise_mask());
        // hold off once until everything has drained
        if (p == 1 && i == 10) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0 || out_valid) @(posedge clk);
          repeat (50) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung search or handshake.
  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
src/sds_pkg.sv
src/sds_datapath.sv
src/sds_ctrl.sv
src/sumset_decomposition_search_top.sv
sim/sumset_decomposition_search_checker.sv
sim/sumset_decomposition_search_top_tb.sv
